>>> rtl/i128alu_pkg.sv
// ============================================================================
// i128alu_pkg: shared definitions for the 128-bit integer arithmetic unit
// ----------------------------------------------------------------------------
// This package holds the action codes, the word and limb widths, and the
// partial-product schedule that the multiply sequencer walks through.
// ============================================================================
package i128alu_pkg;

    // Word, half-word and multiplier limb widths.
    localparam int WORD_W = 128;
    localparam int HALF_W = 64;
    localparam int LIMB_W = 32;
    localparam int STEP_W = $clog2(WORD_W);

    // Action codes.
    localparam logic [3:0] ACT_ADD   = 4'd0;
    localparam logic [3:0] ACT_SUB   = 4'd1;
    localparam logic [3:0] ACT_MUL   = 4'd2;
    localparam logic [3:0] ACT_UDIV  = 4'd3;
    localparam logic [3:0] ACT_UMOD  = 4'd4;
    localparam logic [3:0] ACT_SDIV  = 4'd5;
    localparam logic [3:0] ACT_SMOD  = 4'd6;
    localparam logic [3:0] ACT_MUL64 = 4'd7;
    localparam logic [3:0] ACT_DIV64 = 4'd8;

    // Number of partial products for each multiply action.
    localparam logic [3:0] MUL64_PARTS = 4'd4;
    localparam logic [3:0] MUL_PARTS   = 4'd10;

    // Limb pair {i, j} for partial product k. The first four entries cover a
    // full 64x64 product; all ten cover the low 128 bits of a 128x128 product.
    function automatic logic [3:0] limb_pair(input logic [3:0] k);
        logic [3:0] pair;
        unique case (k)
            4'd0:    pair = {2'd0, 2'd0};
            4'd1:    pair = {2'd0, 2'd1};
            4'd2:    pair = {2'd1, 2'd0};
            4'd3:    pair = {2'd1, 2'd1};
            4'd4:    pair = {2'd0, 2'd2};
            4'd5:    pair = {2'd2, 2'd0};
            4'd6:    pair = {2'd0, 2'd3};
            4'd7:    pair = {2'd1, 2'd2};
            4'd8:    pair = {2'd2, 2'd1};
            4'd9:    pair = {2'd3, 2'd0};
            default: pair = {2'd0, 2'd0};
        endcase
        return pair;
    endfunction

endpackage

>>> rtl/int128_arithmetic_unit.sv
// ============================================================================
// int128_arithmetic_unit: 128-bit integer ALU with a restoring divider
// ----------------------------------------------------------------------------
// Adds, subtracts, multiplies, divides and takes the modulo of 128-bit
// operands, using one shared 129-bit adder and one 32x32 multiplier under a
// small sequencer.
// ============================================================================
// The unit takes one transfer at a time and holds in_stall high until the
// work on it is done; the result then sits in an output register, so a new
// transfer can be taken while that result waits. Add and sub pass once
// through the shared adder. Mul64 and mul form their 32x32 partial products
// one by one on the single multiplier, then drain its product register.
// Unsigned divide, modulo and div64 take one restoring step per dividend bit
// on the shared adder; signed divide and modulo first make the operands
// positive (ST_NEG_A, ST_NEG_B) and afterwards fix the signs (ST_FIX_Q,
// ST_FIX_R). A zero divisor or an unused action code goes straight to
// ST_FINISH. A result that waits on out_stall holds the next item in
// ST_FINISH. The next transfer is accepted the cycle after the result is
// loaded.
module int128_arithmetic_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [3:0]  action,
    input  logic [63:0] a_hi,
    input  logic [63:0] a_lo,
    input  logic [63:0] b_hi,
    input  logic [63:0] b_lo,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] result_hi,
    output logic [63:0] result_lo,
    output logic [63:0] extra_hi,
    output logic [63:0] extra_lo,
    output logic        div_by_zero
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADDSUB,
        ST_MUL,
        ST_NEG_A,
        ST_NEG_B,
        ST_DIV,
        ST_FIX_Q,
        ST_FIX_R,
        ST_FINISH
    } state_t;

    localparam int W  = i128alu_pkg::WORD_W;
    localparam int HW = i128alu_pkg::HALF_W;
    localparam int LW = i128alu_pkg::LIMB_W;
    localparam int SW = i128alu_pkg::STEP_W;

    state_t          state_reg, state_next;
    logic [3:0]      op_reg, op_next;
    logic [W-1:0]    a_reg, a_next;
    logic [W-1:0]    b_reg, b_next;
    logic [W-1:0]    acc_reg, acc_next;
    logic [2*LW-1:0] prod_reg, prod_next;
    logic [1:0]      psh_reg, psh_next;
    logic            pv_reg, pv_next;
    logic [SW-1:0]   cnt_reg, cnt_next;
    logic            neg_q_reg, neg_q_next;
    logic            neg_r_reg, neg_r_next;
    logic            dz_reg, dz_next;
    logic            zero_reg, zero_next;
    logic            out_valid_reg, out_valid_next;
    logic [HW-1:0]   result_hi_reg, result_hi_next;
    logic [HW-1:0]   result_lo_reg, result_lo_next;
    logic [HW-1:0]   extra_hi_reg, extra_hi_next;
    logic [HW-1:0]   extra_lo_reg, extra_lo_next;
    logic            dz_out_reg, dz_out_next;

    // Shared adder: 129-bit operands with a carry out for the divide compare.
    logic [W:0]      add_x, add_y;
    logic            add_cin;
    logic [W+1:0]    add_sum;

    logic [W-1:0]    b_in;
    logic            b_in_zero;
    logic [3:0]      pair;
    logic [LW-1:0]   limb_a, limb_b;
    logic [2*LW-1:0] mul_out;
    logic [3:0]      mul_parts;
    logic [W-1:0]    prod_shifted;
    logic [W:0]      rem_shift;
    logic            is_signed;

    assign add_sum = {1'b0, add_x} + {1'b0, add_y} + {{(W+1){1'b0}}, add_cin};

    // Divisor as seen by the action; div64 takes only the low half.
    assign b_in      = (action == i128alu_pkg::ACT_DIV64) ? {{HW{1'b0}}, b_lo}
                                                          : {b_hi, b_lo};
    assign b_in_zero = (b_in == '0);

    // Multiplier operand selection and the single 32x32 multiplier.
    assign pair      = i128alu_pkg::limb_pair(cnt_reg[3:0]);
    assign limb_a    = a_reg[{pair[3:2], 5'b0} +: LW];
    assign limb_b    = b_reg[{pair[1:0], 5'b0} +: LW];
    assign mul_out   = limb_a * limb_b;
    assign mul_parts = (op_reg == i128alu_pkg::ACT_MUL64) ? i128alu_pkg::MUL64_PARTS
                                                          : i128alu_pkg::MUL_PARTS;
    assign prod_shifted = {{(W-2*LW){1'b0}}, prod_reg} << {psh_reg, 5'b0};

    // Remainder shifted left with the next dividend bit brought in.
    assign rem_shift = {acc_reg, a_reg[W-1]};
    assign is_signed = (op_reg == i128alu_pkg::ACT_SDIV) ||
                       (op_reg == i128alu_pkg::ACT_SMOD);

    // Sequencer next-state and datapath logic.
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        acc_next       = acc_reg;
        prod_next      = prod_reg;
        psh_next       = psh_reg;
        pv_next        = pv_reg;
        cnt_next       = cnt_reg;
        neg_q_next     = neg_q_reg;
        neg_r_next     = neg_r_reg;
        dz_next        = dz_reg;
        zero_next      = zero_reg;
        out_valid_next = out_valid_reg;
        result_hi_next = result_hi_reg;
        result_lo_next = result_lo_reg;
        extra_hi_next  = extra_hi_reg;
        extra_lo_next  = extra_lo_reg;
        dz_out_next    = dz_out_reg;
        add_x          = '0;
        add_y          = '0;
        add_cin        = 1'b0;

        // The output register empties on a completed output transfer.
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = action;
                    a_next     = {a_hi, a_lo};
                    b_next     = b_in;
                    acc_next   = '0;
                    cnt_next   = '0;
                    pv_next    = 1'b0;
                    dz_next    = 1'b0;
                    zero_next  = 1'b0;
                    neg_q_next = a_hi[HW-1] ^ b_hi[HW-1];
                    neg_r_next = a_hi[HW-1];
                    unique case (action)
                        i128alu_pkg::ACT_ADD,
                        i128alu_pkg::ACT_SUB:
                        begin
                            state_next = ST_ADDSUB;
                        end
                        i128alu_pkg::ACT_MUL,
                        i128alu_pkg::ACT_MUL64:
                        begin
                            state_next = ST_MUL;
                        end
                        i128alu_pkg::ACT_UDIV,
                        i128alu_pkg::ACT_UMOD,
                        i128alu_pkg::ACT_DIV64:
                        begin
                            dz_next    = b_in_zero;
                            zero_next  = b_in_zero;
                            state_next = b_in_zero ? ST_FINISH : ST_DIV;
                        end
                        i128alu_pkg::ACT_SDIV,
                        i128alu_pkg::ACT_SMOD:
                        begin
                            dz_next    = b_in_zero;
                            zero_next  = b_in_zero;
                            state_next = b_in_zero ? ST_FINISH : ST_NEG_A;
                        end
                        default:
                        begin
                            zero_next  = 1'b1;
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end

            // Add, or subtract as A plus the inverted B plus one.
            ST_ADDSUB:
            begin
                add_x      = {1'b0, a_reg};
                add_y      = (op_reg == i128alu_pkg::ACT_SUB) ? {1'b0, ~b_reg}
                                                              : {1'b0, b_reg};
                add_cin    = (op_reg == i128alu_pkg::ACT_SUB);
                acc_next   = add_sum[W-1:0];
                state_next = ST_FINISH;
            end

            // One partial product a cycle; the previous one is accumulated.
            ST_MUL:
            begin
                if (pv_reg)
                begin
                    add_x    = {1'b0, acc_reg};
                    add_y    = {1'b0, prod_shifted};
                    acc_next = add_sum[W-1:0];
                end
                if (cnt_reg[3:0] < mul_parts)
                begin
                    prod_next = mul_out;
                    psh_next  = pair[3:2] + pair[1:0];
                    pv_next   = 1'b1;
                    cnt_next  = cnt_reg + 1'b1;
                end
                else
                begin
                    pv_next    = 1'b0;
                    state_next = ST_FINISH;
                end
            end

            // Take the magnitude of a negative dividend.
            ST_NEG_A:
            begin
                add_x      = neg_r_reg ? {1'b0, ~a_reg} : {1'b0, a_reg};
                add_cin    = neg_r_reg;
                a_next     = add_sum[W-1:0];
                state_next = ST_NEG_B;
            end

            // Take the magnitude of a negative divisor.
            ST_NEG_B:
            begin
                add_x      = (neg_q_reg ^ neg_r_reg) ? {1'b0, ~b_reg} : {1'b0, b_reg};
                add_cin    = neg_q_reg ^ neg_r_reg;
                b_next     = add_sum[W-1:0];
                state_next = ST_DIV;
            end

            // One restoring step: the carry out means the divisor fits.
            ST_DIV:
            begin
                add_x    = rem_shift;
                add_y    = ~{1'b0, b_reg};
                add_cin  = 1'b1;
                acc_next = add_sum[W+1] ? add_sum[W-1:0] : rem_shift[W-1:0];
                a_next   = {a_reg[W-2:0], add_sum[W+1]};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == SW'(W - 1))
                begin
                    state_next = is_signed ? ST_FIX_Q : ST_FINISH;
                end
            end

            // Negate the quotient when the operand signs differ.
            ST_FIX_Q:
            begin
                add_x      = neg_q_reg ? {1'b0, ~a_reg} : {1'b0, a_reg};
                add_cin    = neg_q_reg;
                a_next     = add_sum[W-1:0];
                state_next = ST_FIX_R;
            end

            // The remainder follows the sign of the dividend.
            ST_FIX_R:
            begin
                add_x      = neg_r_reg ? {1'b0, ~acc_reg} : {1'b0, acc_reg};
                add_cin    = neg_r_reg;
                acc_next   = add_sum[W-1:0];
                state_next = ST_FINISH;
            end

            // Load the output register once it is free.
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    dz_out_next    = dz_reg;
                    result_hi_next = '0;
                    result_lo_next = '0;
                    extra_hi_next  = '0;
                    extra_lo_next  = '0;
                    if (!zero_reg)
                    begin
                        unique case (op_reg)
                            i128alu_pkg::ACT_UDIV,
                            i128alu_pkg::ACT_SDIV:
                            begin
                                {result_hi_next, result_lo_next} = a_reg;
                                {extra_hi_next, extra_lo_next}   = acc_reg;
                            end
                            i128alu_pkg::ACT_DIV64:
                            begin
                                result_lo_next = a_reg[HW-1:0];
                                extra_lo_next  = acc_reg[HW-1:0];
                            end
                            default:
                            begin
                                {result_hi_next, result_lo_next} = acc_reg;
                            end
                        endcase
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, control and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pv_reg        <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            op_reg        <= '0;
            neg_q_reg     <= 1'b0;
            neg_r_reg     <= 1'b0;
            dz_reg        <= 1'b0;
            zero_reg      <= 1'b0;
            result_hi_reg <= '0;
            result_lo_reg <= '0;
            extra_hi_reg  <= '0;
            extra_lo_reg  <= '0;
            dz_out_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pv_reg        <= pv_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            op_reg        <= op_next;
            neg_q_reg     <= neg_q_next;
            neg_r_reg     <= neg_r_next;
            dz_reg        <= dz_next;
            zero_reg      <= zero_next;
            result_hi_reg <= result_hi_next;
            result_lo_reg <= result_lo_next;
            extra_hi_reg  <= extra_hi_next;
            extra_lo_reg  <= extra_lo_next;
            dz_out_reg    <= dz_out_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        a_reg         <= a_next;
        b_reg         <= b_next;
        acc_reg       <= acc_next;
        prod_reg      <= prod_next;
        psh_reg       <= psh_next;
    end

    assign in_stall    = (state_reg != ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign result_hi   = result_hi_reg;
    assign result_lo   = result_lo_reg;
    assign extra_hi    = extra_hi_reg;
    assign extra_lo    = extra_lo_reg;
    assign div_by_zero = dz_out_reg;

endmodule
